[src/assert_macros.svh]
// Assertion macros used by the bus token poll scheduler top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[src/btps_pkg.sv]
// Types and constants of the bus token poll scheduler
`timescale 1ns / 1ps

package btps_pkg;

  localparam int ADDR_W     = 7;
  localparam int NODE_COUNT = 1 << ADDR_W;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 8;

  typedef logic [ADDR_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  count_t;

  localparam node_t  OWN_ADDR_RESET  = 7'd1;
  localparam count_t MAX_FAILS_RESET = 8'd3;
  localparam count_t LOOPS_RESET     = 8'd10;

  typedef enum logic [1:0] {
    MODE_GRANT   = 2'd0,
    MODE_REPLY   = 2'd1,
    MODE_ANS_TMO = 2'd2,
    MODE_TOK_TMO = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ADDR  = 2'd0,
    CFG_MAX_FAILS = 2'd1,
    CFG_LOOPS     = 2'd2
  } cfg_idx_t;

  // presence map read address source
  typedef enum logic [1:0] {
    RD_SP     = 2'd0,
    RD_SP_ADV = 2'd1,
    RD_PP_ADV = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    init;
    logic    serve_adv;
    logic    probe_start;
    logic    probe_adv;
    logic    hit_serve;
    logic    hit_probe;
    logic    grant;
    logic    event_exec;
    rd_sel_t rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic map_bit;
    logic sp_at_last;
    logic pp_at_start;
    logic probing;
  } dp_status_t;

endpackage

[src/btps_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module btps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/btps_ctrl.sv]
// Controller FSM: sequences the serve walk, probe walk and event handling
`timescale 1ns / 1ps

module btps_ctrl import btps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  mode_t      mode,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SWALK  = 6'b000010,
    ST_SONE   = 6'b000100,
    ST_PSTART = 6'b001000,
    ST_PWALK  = 6'b010000,
    ST_GRANT  = 6'b100000
  } state_t;

  localparam logic [1:0] RUN_LAST = 2'd2;

  state_t     state, state_next;
  logic [1:0] run, run_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      run   <= '0;
    end else begin
      state <= state_next;
      run   <= run_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    run_next   = run;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (mode == MODE_GRANT) begin
            cmd.init = 1'b1;
            run_next = '0;
            if (status.probing) begin
              // after a probe the current serve node is checked again
              cmd.rd_sel = RD_SP;
              state_next = ST_SONE;
            end else if (status.sp_at_last) begin
              // wrap ends the serve walk without a check
              cmd.serve_adv = 1'b1;
              state_next    = ST_PSTART;
            end else begin
              cmd.serve_adv = 1'b1;
              cmd.rd_sel    = RD_SP_ADV;
              state_next    = ST_SWALK;
            end
          end else begin
            cmd.event_exec = 1'b1;
          end
        end
      end
      ST_SWALK: begin
        if (status.map_bit) begin
          cmd.hit_serve = 1'b1;
          state_next    = ST_GRANT;
        end else if (status.sp_at_last) begin
          cmd.serve_adv = 1'b1;
          state_next    = ST_PSTART;
        end else begin
          cmd.serve_adv = 1'b1;
          cmd.rd_sel    = RD_SP_ADV;
        end
      end
      ST_SONE: begin
        if (status.map_bit) begin
          cmd.hit_serve = 1'b1;
          state_next    = ST_GRANT;
        end else begin
          state_next = ST_PSTART;
        end
      end
      ST_PSTART: begin
        cmd.probe_start = 1'b1;
        cmd.probe_adv   = 1'b1;
        cmd.rd_sel      = RD_PP_ADV;
        state_next      = ST_PWALK;
      end
      ST_PWALK: begin
        if (!status.map_bit) begin
          cmd.hit_probe = 1'b1;
          state_next    = ST_GRANT;
        end else if (status.pp_at_start) begin
          // full circle with every node present: retry the serve node until run reaches RUN_LAST, then grant
          if (run == RUN_LAST) begin
            state_next = ST_GRANT;
          end else begin
            run_next   = run + 2'd1;
            cmd.rd_sel = RD_SP;
            state_next = ST_SONE;
          end
        end else begin
          cmd.probe_adv = 1'b1;
          cmd.rd_sel    = RD_PP_ADV;
        end
      end
      ST_GRANT: begin
        cmd.grant  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/btps_dpath.sv]
// Datapath: pointers, presence map, error tracking, sleep countdown, results
`timescale 1ns / 1ps

module btps_dpath import btps_pkg::*; #(
  parameter int FIRST_NODE = 1,
  parameter int LAST_NODE  = 127
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  mode_t                mode,
  input  logic                 reply_has_payload,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output node_t                token_node,
  output logic                 is_discovery,
  output logic                 expects_answer,
  output logic                 node_dropped,
  output logic                 sleep_request
);

  localparam node_t FIRST = ADDR_W'(FIRST_NODE);
  localparam node_t LAST  = ADDR_W'(LAST_NODE);

  function automatic node_t adv(input node_t p);
    node_t r;
    if (p >= LAST) begin
      r = FIRST;
    end else begin
      r = p + ADDR_W'(1);
    end
    return r;
  endfunction

  node_t  own_q;
  count_t max_fails_q, loops_q;

  node_t  sp_q, pp_q, pstart_q, node_q, granted_q, err_node_q;
  count_t err_cnt_q, sc_q;
  logic   pf_q, round_q;

  logic [NODE_COUNT-1:0] valid_q;
  logic                  rd_valid_q;
  logic                  rd_data;
  node_t                 rd_addr;
  logic                  wr_en, wr_data;
  node_t                 wr_addr;

  count_t cnt_inc;
  logic   ce_claim, ce_match, ce_drop, ce_apply;

  assign cnt_inc  = err_cnt_q + CNT_W'(1);
  assign ce_claim = (err_node_q == '0);
  assign ce_match = !ce_claim && (granted_q == err_node_q);
  assign ce_drop  = ce_match && (cnt_inc >= max_fails_q);
  assign ce_apply = (mode == MODE_TOK_TMO) || ((mode == MODE_ANS_TMO) && !pf_q);

  always_comb begin
    case (cmd.rd_sel)
      RD_SP:     rd_addr = sp_q;
      RD_SP_ADV: rd_addr = adv(sp_q);
      RD_PP_ADV: rd_addr = adv(pp_q);
      default:   rd_addr = sp_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = granted_q;
    wr_data = 1'b0;
    if (cmd.grant && (node_q == own_q)) begin
      wr_en   = 1'b1;
      wr_addr = own_q;
      wr_data = 1'b1;
    end
    if (cmd.event_exec) begin
      case (mode)
        MODE_REPLY: begin
          if (pf_q) begin
            wr_en   = 1'b1;
            wr_data = 1'b1;
          end
        end
        MODE_ANS_TMO, MODE_TOK_TMO: begin
          if (ce_apply && ce_drop) begin
            wr_en   = 1'b1;
            wr_data = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  btps_ram #(
    .WIDTH (1),
    .DEPTH (NODE_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // entries never written since reset read as absent
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr];
    end
  end

  assign status.map_bit     = rd_valid_q & rd_data;
  assign status.sp_at_last  = (sp_q >= LAST);
  assign status.pp_at_start = (pp_q == pstart_q);
  assign status.probing     = pf_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_q       <= OWN_ADDR_RESET;
      max_fails_q <= MAX_FAILS_RESET;
      loops_q     <= LOOPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDR:  own_q       <= cfg_data[ADDR_W-1:0];
        CFG_MAX_FAILS: max_fails_q <= cfg_data;
        CFG_LOOPS:     loops_q     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp_q       <= FIRST;
      pp_q       <= FIRST;
      pstart_q   <= FIRST;
      pf_q       <= 1'b1;
      node_q     <= '0;
      granted_q  <= '0;
      err_node_q <= '0;
      err_cnt_q  <= '0;
      sc_q       <= LOOPS_RESET;
      round_q    <= 1'b0;
    end else begin
      if (cmd.init) begin
        node_q  <= sp_q;
        round_q <= 1'b0;
      end
      if (cmd.serve_adv) begin
        sp_q <= adv(sp_q);
      end
      if (cmd.probe_start) begin
        pstart_q <= pp_q;
      end
      if (cmd.probe_adv) begin
        pp_q <= adv(pp_q);
        if (pp_q >= LAST) begin
          round_q <= 1'b1;
        end
      end
      if (cmd.hit_serve) begin
        node_q <= sp_q;
        pf_q   <= 1'b0;
      end
      if (cmd.hit_probe) begin
        node_q <= pp_q;
        pf_q   <= 1'b1;
      end
      if (cmd.grant) begin
        granted_q <= node_q;
        if (round_q && (sc_q != '0)) begin
          sc_q <= sc_q - CNT_W'(1);
        end
      end
      if (cmd.event_exec) begin
        case (mode)
          MODE_REPLY: begin
            if (reply_has_payload) begin
              sc_q <= loops_q;
            end
            if (!pf_q && (granted_q == err_node_q)) begin
              err_node_q <= '0;
              err_cnt_q  <= '0;
            end
          end
          MODE_ANS_TMO, MODE_TOK_TMO: begin
            if (ce_apply) begin
              if (ce_claim) begin
                err_node_q <= granted_q;
              end else if (ce_drop) begin
                err_node_q <= '0;
                err_cnt_q  <= '0;
              end else if (ce_match) begin
                err_cnt_q <= cnt_inc;
              end
            end
            if ((mode == MODE_ANS_TMO) && (sc_q == '0)) begin
              sc_q <= loops_q;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.grant | cmd.event_exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grant) begin
      token_node     <= node_q;
      is_discovery   <= pf_q;
      expects_answer <= (node_q != own_q);
      node_dropped   <= 1'b0;
      sleep_request  <= 1'b0;
    end else if (cmd.event_exec) begin
      token_node     <= granted_q;
      is_discovery   <= pf_q;
      expects_answer <= 1'b0;
      node_dropped   <= ce_apply && ce_drop;
      sleep_request  <= (mode == MODE_ANS_TMO) && (sc_q == '0);
    end
  end

endmodule

[src/bus_token_poll_scheduler.sv]
// Reply, answer timeout and token timeout items: result registered in the cycle after accept, busy stays low.
// Grant items: busy stays high while the serve walk and the probe walk look up the presence map
// (registered read), with a probe walk start state before each probe walk.
// The result strobe (done) follows the end of busy by nothing: it is high in the cycle busy falls.
// Synchronous active-high reset clears the map and error counter, sets pointers to FIRST_NODE, loads register defaults.
// The receiver cannot stall: each result is valid for exactly one cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bus_token_poll_scheduler import btps_pkg::*; #(
  parameter int FIRST_NODE = 1,
  parameter int LAST_NODE  = 127
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           mode,
  input  logic                 reply_has_payload,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output logic [ADDR_W-1:0]    token_node,
  output logic                 is_discovery,
  output logic                 expects_answer,
  output logic                 node_dropped,
  output logic                 sleep_request
);

  dp_cmd_t    cmd;
  dp_status_t status;
  mode_t      mode_in;

  assign mode_in = mode_t'(mode);

  btps_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode_in),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  btps_dpath #(
    .FIRST_NODE (FIRST_NODE),
    .LAST_NODE  (LAST_NODE)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .mode              (mode_in),
    .reply_has_payload (reply_has_payload),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .done              (done),
    .token_node        (token_node),
    .is_discovery      (is_discovery),
    .expects_answer    (expects_answer),
    .node_dropped      (node_dropped),
    .sleep_request     (sleep_request)
  );

  `ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, done || busy)
  `ASSERT_IMPLIES(a_done_idle, clk, rst, done, !busy)
  `ASSERT_IMPLIES(a_grant_done, clk, rst, $fell(busy), done)
  `ASSERT_IMPLIES(a_expects_alone, clk, rst, done && expects_answer, !node_dropped && !sleep_request)

endmodule
